/* hw/rtl/rgb2lab_pkg.sv */
// Shared types and constants for the RGB to CIE L*a*b* pipeline.
// No dependencies; every rgb2lab module imports this package.
package rgb2lab_pkg;

    // Per-stage load enables, driven by the top-level flow control
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } stage_en_t;

    // Input pixel and normalized channel (Q24) widths
    localparam int PIX_W = 24;
    localparam int CH_W  = 8;
    localparam int T_W   = 24;

    // Linear segment only sees t24 at or below the knee, which fits in 18 bits
    localparam int LIN_T_W = 18;

    // Knee 0.008856 in Q24
    localparam logic [T_W-1:0] THR24 = 24'd148579;

    // Cube-root table: 2^SEG_BITS segments over [0,1]
    localparam int SEG_BITS = 10;
    localparam int LOW_BITS = T_W - SEG_BITS;

    // 7.787 in Q16 and 16/116 in Q40 for the linear f() segment
    localparam int          K_LIN_W   = 19;
    localparam logic [63:0] K_LIN_Q16 = 64'd510329;
    localparam logic [63:0] C_LIN_Q40 = 64'd151656776245;

    // 903.3 in Q16 for L* below the knee
    localparam int          K_L_W   = 26;
    localparam logic [63:0] K_L_Q16 = 64'd59198669;

    // Result field widths
    localparam int L_W = 15;
    localparam int A_W = 19;
    localparam int B_W = 18;

endpackage

/* hw/rtl/rgb_to_lab_converter.sv */
// Top level of the RGB to CIE L*a*b* (D65) converter: flow control and stage wiring.
// Depends on rgb2lab_pkg, rgb2lab_matrix, rgb2lab_fcurve, rgb2lab_combine.

// A packed 24-bit RGB pixel (red 23:16, green 15:8, blue 7:0) is converted to
// L* (0..25600) and a*+128, b*+128 in units of 1/256, with no gamma step. The
// block takes one pixel every clock unless m_ready holds a full pipeline, and each
// pixel passes six register stages: matrix, knot ROM read, interpolation multiply,
// segment select, L*a*b* scaling and the Q8 output register. Each channel owns a
// 1025-knot cube-root ROM split into even and odd banks with a registered read, so
// both interpolation knots come out in the same cycle. Every stage carries its own
// valid bit and loads whenever its successor can take its item, so empty stages
// are filled even while a result waits on m_ready. No reset pass is needed.
module rgb_to_lab_converter
    import rgb2lab_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PIX_W-1:0]      s_pixel,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [L_W-1:0]        m_lightness,
    output logic signed [A_W-1:0] m_a_star,
    output logic signed [B_W-1:0] m_b_star
);

    localparam int NSTAGE = 6;

    logic [NSTAGE-1:0] valid_reg, valid_next;
    logic [NSTAGE-1:0] en_vec;
    stage_en_t         en;

    logic [T_W-1:0]     t_x, t_y, t_z;
    logic [FRAC_BITS:0] f_x, f_y, f_z;
    logic               up_x, up_y, up_z;

    // Stage k loads when it is empty or stage k+1 loads this cycle
    always_comb begin
        en_vec[NSTAGE-1] = !valid_reg[NSTAGE-1] || m_ready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            en_vec[k] = !valid_reg[k] || en_vec[k+1];
        end
    end

    assign en.s1 = en_vec[0];
    assign en.s2 = en_vec[1];
    assign en.s3 = en_vec[2];
    assign en.s4 = en_vec[3];
    assign en.s5 = en_vec[4];
    assign en.s6 = en_vec[5];

    // Valid bits travel with the data
    always_comb begin
        valid_next = valid_reg;
        if (en_vec[0]) begin
            valid_next[0] = s_valid;
        end
        for (int k = 1; k < NSTAGE; k++) begin
            if (en_vec[k]) begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = en_vec[0];
    assign m_valid = valid_reg[NSTAGE-1];

    rgb2lab_matrix u_matrix (
        .aclk  (aclk),
        .en    (en),
        .pixel (s_pixel),
        .t_x   (t_x),
        .t_y   (t_y),
        .t_z   (t_z)
    );

    rgb2lab_fcurve #(.FRAC_BITS(FRAC_BITS)) u_fx (
        .aclk  (aclk),
        .en    (en),
        .t_in  (t_x),
        .f_out (f_x),
        .upper (up_x)
    );

    rgb2lab_fcurve #(.FRAC_BITS(FRAC_BITS)) u_fy (
        .aclk  (aclk),
        .en    (en),
        .t_in  (t_y),
        .f_out (f_y),
        .upper (up_y)
    );

    rgb2lab_fcurve #(.FRAC_BITS(FRAC_BITS)) u_fz (
        .aclk  (aclk),
        .en    (en),
        .t_in  (t_z),
        .f_out (f_z),
        .upper (up_z)
    );

    rgb2lab_combine #(.FRAC_BITS(FRAC_BITS)) u_combine (
        .aclk      (aclk),
        .en        (en),
        .t_y       (t_y),
        .f_x       (f_x),
        .f_y       (f_y),
        .f_z       (f_z),
        .y_upper   (up_y),
        .lightness (m_lightness),
        .a_star    (m_a_star),
        .b_star    (m_b_star)
    );

    // X and Z branch flags are consumed inside their own f() units
    logic unused_flags;
    assign unused_flags = up_x ^ up_z;

`ifndef SYNTHESIS
    logic in_acc, out_acc;
    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    // Items in flight change only by what enters and leaves
    a_item_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |->
            ($countones(valid_reg) + $past(out_acc)
             == $countones($past(valid_reg)) + $past(in_acc)))
        else $error("pipeline lost or duplicated an item");

    a_l_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_lightness <= 15'd25600))
        else $error("L* out of range");

    a_a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_a_star >= -19'sd77600 && m_a_star <= 19'sd143200))
        else $error("a* out of range");

    a_b_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_b_star >= -18'sd11400 && m_b_star <= 18'sd77000))
        else $error("b* out of range");
`endif

endmodule

/* hw/rtl/rgb2lab_matrix.sv */
// Stage 1: RGB to normalized XYZ (Q24) with the D65 white folded into the matrix.
// Depends on rgb2lab_pkg.
module rgb2lab_matrix
    import rgb2lab_pkg::*;
(
    input  logic             aclk,
    input  stage_en_t        en,
    input  logic [PIX_W-1:0] pixel,
    output logic [T_W-1:0]   t_x,
    output logic [T_W-1:0]   t_y,
    output logic [T_W-1:0]   t_z
);

    localparam int COEF_W = 16;
    localparam int SUM_W  = T_W + 2;

    // round(m / (255 * white) * 2^24), rows X, Y, Z
    localparam logic [COEF_W-1:0] CX_R = 16'd28551;
    localparam logic [COEF_W-1:0] CX_G = 16'd24753;
    localparam logic [COEF_W-1:0] CX_B = 16'd12489;
    localparam logic [COEF_W-1:0] CY_R = 16'd13992;
    localparam logic [COEF_W-1:0] CY_G = 16'd47053;
    localparam logic [COEF_W-1:0] CY_B = 16'd4748;
    localparam logic [COEF_W-1:0] CZ_R = 16'd1168;
    localparam logic [COEF_W-1:0] CZ_G = 16'd7203;
    localparam logic [COEF_W-1:0] CZ_B = 16'd57422;

    logic [CH_W-1:0]  ch_r, ch_g, ch_b;
    logic [SUM_W-1:0] sum_x, sum_y, sum_z;
    logic [T_W-1:0]   tx_reg, ty_reg, tz_reg;

    assign ch_r = pixel[23:16];
    assign ch_g = pixel[15:8];
    assign ch_b = pixel[7:0];

    // Three dot products; each row sums to 65793, so 255 * row < 2^24
    always_comb begin
        sum_x = SUM_W'(CX_R) * SUM_W'(ch_r) + SUM_W'(CX_G) * SUM_W'(ch_g)
              + SUM_W'(CX_B) * SUM_W'(ch_b);
        sum_y = SUM_W'(CY_R) * SUM_W'(ch_r) + SUM_W'(CY_G) * SUM_W'(ch_g)
              + SUM_W'(CY_B) * SUM_W'(ch_b);
        sum_z = SUM_W'(CZ_R) * SUM_W'(ch_r) + SUM_W'(CZ_G) * SUM_W'(ch_g)
              + SUM_W'(CZ_B) * SUM_W'(ch_b);
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            tx_reg <= sum_x[T_W-1:0];
            ty_reg <= sum_y[T_W-1:0];
            tz_reg <= sum_z[T_W-1:0];
        end
    end

    assign t_x = tx_reg;
    assign t_y = ty_reg;
    assign t_z = tz_reg;

endmodule

/* hw/rtl/rgb2lab_lin.sv */
// Stages 2-3: round((t * K + C) / 2^(40 - FRAC_BITS)) for a small t.
// Depends on rgb2lab_pkg. Used for the linear f() segment and low-range L*.
module rgb2lab_lin
    import rgb2lab_pkg::*;
#(
    parameter int          FRAC_BITS = 8,
    parameter int          K_WIDTH   = 19,
    parameter logic [63:0] K_VALUE   = 64'd510329,
    parameter logic [63:0] C_VALUE   = 64'd0
) (
    input  logic                   aclk,
    input  stage_en_t              en,
    input  logic [LIN_T_W-1:0]     t_in,
    output logic [FRAC_BITS+3:0]   res
);

    localparam int          OW  = FRAC_BITS + 4;
    localparam int          PW  = LIN_T_W + K_WIDTH;
    localparam int          SW  = ((PW > 40) ? PW : 40) + 1;
    localparam int          SH  = 40 - FRAC_BITS;
    localparam logic [63:0] RND = 64'd1 << (SH - 1);

    logic [PW-1:0] prod_reg;
    logic [SW-1:0] sum;
    logic [OW-1:0] res_reg;

    // Stage 2: product
    always_ff @(posedge aclk) begin
        if (en.s2) begin
            prod_reg <= PW'(t_in) * PW'(K_VALUE[K_WIDTH-1:0]);
        end
    end

    // Stage 3: offset, round and scale
    assign sum = SW'(prod_reg) + SW'(C_VALUE) + SW'(RND);

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            res_reg <= OW'(sum >> SH);
        end
    end

    assign res = res_reg;

endmodule

/* hw/rtl/rgb2lab_fcurve.sv */
// Stages 2-4: CIE f(t) for one channel, cube root from an interpolated knot ROM
// above the knee and the linear segment below it. Depends on rgb2lab_pkg, rgb2lab_lin.
module rgb2lab_fcurve
    import rgb2lab_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic               aclk,
    input  stage_en_t          en,
    input  logic [T_W-1:0]     t_in,
    output logic [FRAC_BITS:0] f_out,
    output logic               upper
);

    localparam int KW      = FRAC_BITS + 1;
    localparam int SEGS    = 1 << SEG_BITS;
    localparam int EVEN_N  = SEGS / 2 + 1;
    localparam int ODD_N   = SEGS / 2;
    localparam int EVEN_AW = SEG_BITS;
    localparam int ODD_AW  = SEG_BITS - 1;
    localparam int PRW     = KW + LOW_BITS;
    localparam int KSH     = 3 * FRAC_BITS - SEG_BITS;

    typedef logic [KW-1:0] even_rom_t [0:EVEN_N-1];
    typedef logic [KW-1:0] odd_rom_t  [0:ODD_N-1];

    // Rounded integer cube root, evaluated at elaboration only
    function automatic longint unsigned cbrt_round(longint unsigned n);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned c;
        longint unsigned s;
        lo = 0;
        hi = 64'd1 << 17;
        for (int k = 0; k < 20; k++) begin
            if (hi - lo > 1) begin
                mid = (lo + hi) >> 1;
                if (mid * mid * mid <= n) begin
                    lo = mid;
                end else begin
                    hi = mid;
                end
            end
        end
        c = lo;
        s = 2 * c + 1;
        if (8 * n >= s * s * s) begin
            c = c + 1;
        end
        return c;
    endfunction

    function automatic logic [KW-1:0] knot_val(int i);
        longint unsigned n;
        n = longint'(i) << KSH;
        return KW'(cbrt_round(n));
    endfunction

    function automatic even_rom_t build_even();
        even_rom_t r;
        for (int i = 0; i < EVEN_N; i++) begin
            r[i] = knot_val(2 * i);
        end
        return r;
    endfunction

    function automatic odd_rom_t build_odd();
        odd_rom_t r;
        for (int i = 0; i < ODD_N; i++) begin
            r[i] = knot_val(2 * i + 1);
        end
        return r;
    endfunction

    // Knots split by parity so knot[idx] and knot[idx+1] come from different banks
    localparam even_rom_t EVEN_ROM = build_even();
    localparam odd_rom_t  ODD_ROM  = build_odd();

    logic [SEG_BITS-1:0] idx;
    logic [EVEN_AW-1:0]  even_addr;
    logic [ODD_AW-1:0]   odd_addr;

    logic [KW-1:0]       even_q_reg, odd_q_reg;
    logic                odd_lo_reg;
    logic [LOW_BITS-1:0] fr2_reg;
    logic                up2_reg, up3_reg, up4_reg;

    logic [KW-1:0]       knot_lo, knot_hi, knot_d;
    logic [KW-1:0]       lo3_reg;
    logic [PRW-1:0]      prod3_reg;
    logic [PRW-1:0]      prod_rnd;
    logic [KW-1:0]       f_cbrt;
    logic [KW-1:0]       f4_reg;
    logic [FRAC_BITS+3:0] f_lin;

    assign idx       = t_in[T_W-1:LOW_BITS];
    assign odd_addr  = idx[SEG_BITS-1:1];
    assign even_addr = EVEN_AW'(idx[SEG_BITS-1:1]) + EVEN_AW'(idx[0]);

    // Stage 2: ROM read, carry fraction and branch flag
    always_ff @(posedge aclk) begin
        if (en.s2) begin
            even_q_reg <= EVEN_ROM[even_addr];
            odd_q_reg  <= ODD_ROM[odd_addr];
            odd_lo_reg <= idx[0];
            fr2_reg    <= t_in[LOW_BITS-1:0];
            up2_reg    <= (t_in > THR24);
        end
    end

    // Linear segment below the knee
    rgb2lab_lin #(
        .FRAC_BITS (FRAC_BITS),
        .K_WIDTH   (K_LIN_W),
        .K_VALUE   (K_LIN_Q16),
        .C_VALUE   (C_LIN_Q40)
    ) u_lin (
        .aclk (aclk),
        .en   (en),
        .t_in (t_in[LIN_T_W-1:0]),
        .res  (f_lin)
    );

    // Stage 3: knot delta times fraction
    always_comb begin
        knot_lo = odd_lo_reg ? odd_q_reg : even_q_reg;
        knot_hi = odd_lo_reg ? even_q_reg : odd_q_reg;
        knot_d  = knot_hi - knot_lo;
    end

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            lo3_reg   <= knot_lo;
            prod3_reg <= PRW'(knot_d) * PRW'(fr2_reg);
            up3_reg   <= up2_reg;
        end
    end

    // Stage 4: rounded interpolation and branch select
    assign prod_rnd = prod3_reg + PRW'(1 << (LOW_BITS - 1));
    assign f_cbrt   = lo3_reg + KW'(prod_rnd >> LOW_BITS);

    always_ff @(posedge aclk) begin
        if (en.s4) begin
            f4_reg  <= up3_reg ? f_cbrt : KW'(f_lin);
            up4_reg <= up3_reg;
        end
    end

    assign f_out = f4_reg;
    assign upper = up4_reg;

endmodule

/* hw/rtl/rgb2lab_combine.sv */
// Stages 2-6: low-range L* path, then L*, a*, b* from f(X), f(Y), f(Z) and
// rescaling to Q8 in the output register. Depends on rgb2lab_pkg, rgb2lab_lin.
module rgb2lab_combine
    import rgb2lab_pkg::*;
#(
    parameter int FRAC_BITS = 8
) (
    input  logic                  aclk,
    input  stage_en_t             en,
    input  logic [T_W-1:0]        t_y,
    input  logic [FRAC_BITS:0]    f_x,
    input  logic [FRAC_BITS:0]    f_y,
    input  logic [FRAC_BITS:0]    f_z,
    input  logic                  y_upper,
    output logic [L_W-1:0]        lightness,
    output logic signed [A_W-1:0] a_star,
    output logic signed [B_W-1:0] b_star
);

    localparam int W      = FRAC_BITS + 12;
    localparam int QW     = 20;
    localparam int SHR_Q8 = (FRAC_BITS > 8) ? FRAC_BITS - 8 : 0;
    localparam int SHL_Q8 = (FRAC_BITS < 8) ? 8 - FRAC_BITS : 0;

    localparam logic signed [W-1:0] RND_Q8 =
        (FRAC_BITS > 8) ? W'(longint'(1) << (FRAC_BITS - 9)) : '0;
    localparam logic signed [W-1:0] K116   = W'(116);
    localparam logic signed [W-1:0] K500   = W'(500);
    localparam logic signed [W-1:0] K200   = W'(200);
    localparam logic signed [W-1:0] OFS16  = W'(longint'(16) << FRAC_BITS);
    localparam logic signed [W-1:0] OFS128 = W'(longint'(128) << FRAC_BITS);

    // Q(FRAC_BITS) to Q8, ties rounded toward +infinity
    function automatic logic signed [QW-1:0] to_q8(logic signed [W-1:0] v);
        logic signed [W-1:0] r;
        r = (v + RND_Q8) >>> SHR_Q8;
        return QW'(r) <<< SHL_Q8;
    endfunction

    logic [FRAC_BITS+3:0]  l_low;
    logic [FRAC_BITS+3:0]  l_low4_reg;

    logic signed [W-1:0]   fxw, fyw, fzw, llw;
    logic signed [W-1:0]   l_calc, a_calc, b_calc;
    logic signed [W-1:0]   l5_reg, a5_reg, b5_reg;

    logic [L_W-1:0]        l6_reg;
    logic signed [A_W-1:0] a6_reg;
    logic signed [B_W-1:0] b6_reg;

    // L* below the knee: 903.3 * Y
    rgb2lab_lin #(
        .FRAC_BITS (FRAC_BITS),
        .K_WIDTH   (K_L_W),
        .K_VALUE   (K_L_Q16),
        .C_VALUE   (64'd0)
    ) u_llow (
        .aclk (aclk),
        .en   (en),
        .t_in (t_y[LIN_T_W-1:0]),
        .res  (l_low)
    );

    // Stage 4: align with f() results
    always_ff @(posedge aclk) begin
        if (en.s4) begin
            l_low4_reg <= l_low;
        end
    end

    // Stage 5: L*, a* + 128, b* + 128 in Q(FRAC_BITS)
    always_comb begin
        fxw    = W'(f_x);
        fyw    = W'(f_y);
        fzw    = W'(f_z);
        llw    = W'(l_low4_reg);
        l_calc = y_upper ? (fyw * K116 - OFS16) : llw;
        a_calc = (fxw - fyw) * K500 + OFS128;
        b_calc = (fyw - fzw) * K200 + OFS128;
    end

    always_ff @(posedge aclk) begin
        if (en.s5) begin
            l5_reg <= l_calc;
            a5_reg <= a_calc;
            b5_reg <= b_calc;
        end
    end

    // Stage 6: rescale into the output register
    always_ff @(posedge aclk) begin
        if (en.s6) begin
            l6_reg <= L_W'(to_q8(l5_reg));
            a6_reg <= A_W'(to_q8(a5_reg));
            b6_reg <= B_W'(to_q8(b5_reg));
        end
    end

    assign lightness = l6_reg;
    assign a_star    = a6_reg;
    assign b_star    = b6_reg;

endmodule

/* tb/rgb_to_lab_converter_tb.sv */
// Self-checking testbench for rgb_to_lab_converter (packed RGB to CIE L*a*b*, D65 white).
// Depends on rgb2lab_pkg for port widths; drives the top with valid/ready on both channels.
// A bit-exact fixed-point predictor in a small scoreboard class checks every result item.
module rgb_to_lab_converter_tb
    import rgb2lab_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS    = 8;
    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 10;
    localparam int PIPE_LATENCY = 6;
    localparam int LONG_HOLD    = 40;
    localparam int CYCLE_LIMIT  = 200000;

    // Fixed-point constants of the conversion
    localparam longint KNEE_Q24       = 148579;
    localparam longint LIN_SLOPE_Q16  = 510329;
    localparam longint LIN_OFFSET_Q40 = 64'd151656776245;
    localparam longint LOW_L_GAIN_Q16 = 59198669;
    localparam int     CBRT_SEG_BITS  = 10;
    localparam int     CBRT_SEGS      = 1 << CBRT_SEG_BITS;
    localparam int     CBRT_LOW_BITS  = 24 - CBRT_SEG_BITS;

    // RGB to normalized XYZ (white folded in), Q24 per 8-bit code
    localparam longint XYZ_COEF [3][3] = '{
        '{28551, 24753, 12489},
        '{13992, 47053, 4748},
        '{1168, 7203, 57422}
    };

    localparam logic [PIX_W-1:0] DIRECTED_PIXELS [21] = '{
        24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
        24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h000300, 24'h000400,
        24'h050000, 24'h060000, 24'h000002, 24'h000003, 24'h010101,
        24'h808080, 24'h7F7F7F, 24'h555555, 24'hAAAAAA, 24'h030502,
        24'h040603
    };

    typedef struct {
        logic [L_W-1:0]        lightness;
        logic signed [A_W-1:0] a_star;
        logic signed [B_W-1:0] b_star;
    } lab_result_t;

    // Scoreboard: predicts L*a*b* per accepted pixel and checks results in order
    class lab_scoreboard;
        longint      cbrt_knot [CBRT_SEGS + 1];
        lab_result_t pending_lab [$];
        int          errors;

        function new();
            for (int i = 0; i <= CBRT_SEGS; i++)
                cbrt_knot[i] = nearest_cbrt(longint'(i) << (3 * FRAC_BITS - CBRT_SEG_BITS));
            errors = 0;
        endfunction

        function longint round_shift(longint v, int sh);
            return (v + (longint'(1) << (sh - 1))) >>> sh;
        endfunction

        // Integer cube root rounded to nearest
        function longint nearest_cbrt(longint n);
            longint lo;
            longint hi;
            longint mid;
            longint s;
            lo = 0;
            hi = longint'(1) << 17;
            while (hi - lo > 1) begin
                mid = (lo + hi) / 2;
                if (mid * mid * mid <= n) lo = mid;
                else hi = mid;
            end
            s = 2 * lo + 1;
            if (8 * n >= s * s * s) lo++;
            return lo;
        endfunction

        // f(t): interpolated cube root above the knee, linear segment below
        function longint lab_curve(longint t);
            longint idx;
            longint fr;
            longint d;
            if (t > KNEE_Q24) begin
                idx = (t >> CBRT_LOW_BITS) & (CBRT_SEGS - 1);
                fr  = t & ((longint'(1) << CBRT_LOW_BITS) - 1);
                d   = cbrt_knot[idx + 1] - cbrt_knot[idx];
                return cbrt_knot[idx] + round_shift(d * fr, CBRT_LOW_BITS);
            end
            return round_shift(t * LIN_SLOPE_Q16 + LIN_OFFSET_Q40, 40 - FRAC_BITS);
        endfunction

        // Q(FRAC_BITS) to Q8, ties toward +infinity
        function longint requant_q8(longint v);
            longint u;
            u = v + (longint'(1024) << FRAC_BITS);
            if (FRAC_BITS > 8) u = round_shift(u, FRAC_BITS - 8);
            else if (FRAC_BITS < 8) u = u << (8 - FRAC_BITS);
            return u - 1024 * 256;
        endfunction

        function lab_result_t convert_pixel(logic [PIX_W-1:0] px);
            longint      chan [3];
            longint      t [3];
            longint      f [3];
            longint      l_q;
            longint      a_q;
            longint      b_q;
            lab_result_t r;
            chan[0] = px[23:16];
            chan[1] = px[15:8];
            chan[2] = px[7:0];
            for (int k = 0; k < 3; k++) begin
                t[k] = XYZ_COEF[k][0] * chan[0] + XYZ_COEF[k][1] * chan[1]
                     + XYZ_COEF[k][2] * chan[2];
                f[k] = lab_curve(t[k]);
            end
            if (t[1] > KNEE_Q24)
                l_q = 116 * f[1] - (longint'(16) << FRAC_BITS);
            else
                l_q = round_shift(t[1] * LOW_L_GAIN_Q16, 40 - FRAC_BITS);
            a_q = 500 * (f[0] - f[1]) + (longint'(128) << FRAC_BITS);
            b_q = 200 * (f[1] - f[2]) + (longint'(128) << FRAC_BITS);
            l_q = requant_q8(l_q);
            a_q = requant_q8(a_q);
            b_q = requant_q8(b_q);
            r.lightness = l_q[L_W-1:0];
            r.a_star    = a_q[A_W-1:0];
            r.b_star    = b_q[B_W-1:0];
            return r;
        endfunction

        function void note_pixel(logic [PIX_W-1:0] px);
            pending_lab.insert(pending_lab.size(), convert_pixel(px));
        endfunction

        function void check_result(logic [L_W-1:0] l, logic signed [A_W-1:0] a,
                                   logic signed [B_W-1:0] b);
            lab_result_t e;
            if (pending_lab.size() == 0) begin
                $error("result item with no pixel pending: L=%0d a=%0d b=%0d", l, a, b);
                errors++;
                return;
            end
            e = pending_lab.pop_front();
            if (l !== e.lightness) begin
                $error("lightness mismatch: expected %0d, got %0d", e.lightness, l);
                errors++;
            end
            if (a !== e.a_star) begin
                $error("a_star mismatch: expected %0d, got %0d", e.a_star, a);
                errors++;
            end
            if (b !== e.b_star) begin
                $error("b_star mismatch: expected %0d, got %0d", e.b_star, b);
                errors++;
            end
        endfunction

        function int pending();
            return pending_lab.size();
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [PIX_W-1:0]      s_pixel;
    logic                  m_valid;
    logic                  m_ready;
    logic [L_W-1:0]        m_lightness;
    logic signed [A_W-1:0] m_a_star;
    logic signed [B_W-1:0] m_b_star;

    lab_scoreboard board;
    int            tx_idle_pct = 0;
    int            rx_idle_pct = 0;
    bit            long_hold_req = 1'b0;
    int            cycle_count = 0;

    rgb_to_lab_converter #(
        .FRAC_BITS(FRAC_BITS)
    ) u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_pixel    (s_pixel),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_lightness(m_lightness),
        .m_a_star   (m_a_star),
        .m_b_star   (m_b_star)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("rgb_to_lab_converter verification failed");
            $finish;
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result(m_lightness, m_a_star, m_b_star);
    end

    // Result-side ready: random stall bursts plus one long hold on request
    initial begin : result_ready_driver
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
            end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 4) - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Channels biased toward zero, the knee and full scale
    function automatic logic [CH_W-1:0] random_channel();
        int mode;
        mode = $urandom_range(0, 9);
        if (mode <= 5) return CH_W'($urandom_range(0, 255));
        if (mode <= 7) return CH_W'($urandom_range(0, 8));
        if (mode == 8) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        return CH_W'($urandom_range(250, 255));
    endfunction

    function automatic logic [PIX_W-1:0] random_pixel();
        return {random_channel(), random_channel(), random_channel()};
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic offer_pixel(input logic [PIX_W-1:0] px);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel <= px;
        do @(posedge aclk); while (!s_ready);
        board.note_pixel(px);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (board.pending() != 0) @(negedge aclk);
    endtask

    initial begin : stimulus
        int pct_choice [3];
        board = new();
        pct_choice = '{0, 15, 40};
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_pixel = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: corners, primaries, knee crossings per channel
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        foreach (DIRECTED_PIXELS[i]) offer_pixel(DIRECTED_PIXELS[i]);

        // Long output stall while the input keeps offering, so the pipe backs up
        tx_idle_pct = 0;
        long_hold_req = 1'b1;
        repeat (30) offer_pixel(random_pixel());

        // Sender pause until everything has drained
        s_valid <= 1'b0;
        wait_drained();

        // Random phases with varying idle density on each side
        for (int phase = 0; phase < 7; phase++) begin
            tx_idle_pct = pct_choice[$urandom_range(0, 2)];
            rx_idle_pct = pct_choice[$urandom_range(0, 2)];
            repeat (100) offer_pixel(random_pixel());
        end

        // Tail at full rate on both sides
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (100) offer_pixel(random_pixel());
        s_valid <= 1'b0;

        wait_drained();
        repeat (PIPE_LATENCY + 4) @(negedge aclk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("rgb_to_lab_converter verification clean");
        end else begin
            $display("rgb_to_lab_converter verification failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/rgb2lab_pkg.sv
hw/rtl/rgb2lab_matrix.sv
hw/rtl/rgb2lab_lin.sv
hw/rtl/rgb2lab_fcurve.sv
hw/rtl/rgb2lab_combine.sv
hw/rtl/rgb_to_lab_converter.sv
tb/rgb_to_lab_converter_tb.sv
